>>> hw/rtl/cro_pkg.sv
// Shared constants and helper functions for the chirp rotation oscillator.
package cro_pkg;

   // Defaults and fixed-point constants
   localparam int unsigned SWEEP_LEN_DEFAULT = 2048;
   localparam logic [15:0] RATE_HZ_RESET = 16'd11025;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // Exact reciprocals ceil(2^(30+l)/k), l = ceil(log2 k), valid for dividends below 2^30
   localparam logic [31:0] MAGIC_72 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
   localparam logic [31:0] MAGIC_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
   localparam logic [31:0] MAGIC_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
   localparam logic [31:0] MAGIC_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
   localparam logic [31:0] MAGIC_90 = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
   localparam logic [31:0] MAGIC_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
   localparam logic [31:0] MAGIC_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
   localparam logic [31:0] MAGIC_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
   localparam logic [31:0] MAGIC_2  = 32'(((64'd1 << 31) + 64'd1) / 64'd2);

   // Reciprocal for the n-th divide of the sine/cosine Horner chains
   function automatic logic [31:0] poly_magic(input logic [3:0] sel);
      logic [31:0] m;
      unique case (sel)
         4'd0: m = MAGIC_72;
         4'd1: m = MAGIC_42;
         4'd2: m = MAGIC_20;
         4'd3: m = MAGIC_6;
         4'd4: m = MAGIC_90;
         4'd5: m = MAGIC_56;
         4'd6: m = MAGIC_30;
         4'd7: m = MAGIC_12;
         4'd8: m = MAGIC_2;
         default: m = MAGIC_2;
      endcase
      return m;
   endfunction

   // Matching right shift for the reciprocal above
   function automatic logic [5:0] poly_shift(input logic [3:0] sel);
      logic [5:0] s;
      unique case (sel)
         4'd0: s = 6'd37;
         4'd1: s = 6'd36;
         4'd2: s = 6'd35;
         4'd3: s = 6'd33;
         4'd4: s = 6'd37;
         4'd5: s = 6'd36;
         4'd6: s = 6'd35;
         4'd7: s = 6'd34;
         4'd8: s = 6'd31;
         default: s = 6'd31;
      endcase
      return s;
   endfunction

endpackage

>>> hw/rtl/cro_queue.sv
// Small flop-based queue between the front and back parts.
module cro_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = cro_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entry data
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/cro_front.sv
// Front part: accept a request and form the sweep phase numerator.
module cro_front #(
   parameter int unsigned SWEEP_LEN = cro_pkg::SWEEP_LEN_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  logic          restart,
   input  logic [15:0]   freq_start,
   input  logic [15:0]   freq_end,
   input  logic [10:0]   sample_index,
   input  logic          q_full,
   output logic          q_push,
   output logic [$clog2(longint'(SWEEP_LEN) * 64'd65536 + 64'd134217728)+1:0] q_data
);
   localparam int unsigned MW = $clog2(longint'(SWEEP_LEN) * 64'd65536 + 64'd134217728);
   localparam int unsigned NW = MW + 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 restart_ff;
   logic [15:0]          fa_ff, fb_ff;
   logic [10:0]          idx_ff;
   logic signed [NW-1:0] n_ff, n_in;
   logic signed [NW-1:0] fa_s, fb_s, idx_s, len_s;
   logic                 accept;

   assign full   = busy_ff;
   assign accept = push && !busy_ff;
   assign q_push = busy_ff && done_ff && !q_full;
   assign q_data = {restart_ff, n_ff};

   // Form n = fa*L + (fb - fa)*idx
   always_comb begin
      fa_s  = $signed(NW'(fa_ff));
      fb_s  = $signed(NW'(fb_ff));
      idx_s = $signed(NW'(idx_ff));
      len_s = $signed(NW'(SWEEP_LEN));
      n_in  = fa_s * len_s + (fb_s - fa_s) * idx_s;
   end

   // Hold one item from transfer until it enters the queue
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      if (accept) begin
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff && !done_ff) begin
         done_in = 1'b1;
      end else if (q_push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         restart_ff <= restart;
         fa_ff      <= freq_start;
         fb_ff      <= freq_end;
         idx_ff     <= sample_index;
      end
      if (busy_ff && !done_ff) begin
         n_ff <= n_in;
      end
   end

endmodule

>>> hw/rtl/cro_back.sv
// Back part: phase reduction, sine/cosine evaluation, rotation and result register.
module cro_back #(
   parameter int unsigned SWEEP_LEN = cro_pkg::SWEEP_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          rate_hz,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic [$clog2(longint'(SWEEP_LEN) * 64'd65536 + 64'd134217728)+1:0] q_data,
   output logic                 out_empty,
   input  logic                 out_pop,
   output logic signed [15:0]   out_sample
);
   localparam int unsigned MW = $clog2(longint'(SWEEP_LEN) * 64'd65536 + 64'd134217728);
   localparam int unsigned NW = MW + 1;
   localparam int unsigned DW = $clog2(longint'(SWEEP_LEN) * 64'd65536);
   localparam int unsigned CNT_W = $clog2(((MW > 32) ? MW : 32) + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RATE = 4'd1;
   localparam logic [3:0] ST_MOD  = 4'd2;
   localparam logic [3:0] ST_FIX  = 4'd3;
   localparam logic [3:0] ST_FRAC = 4'd4;
   localparam logic [3:0] ST_PHI  = 4'd5;
   localparam logic [3:0] ST_Z    = 4'd6;
   localparam logic [3:0] ST_POLY = 4'd7;
   localparam logic [3:0] ST_MAP  = 4'd8;
   localparam logic [3:0] ST_ROT  = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [MW-1:0]        mag_ff, mag_in;
   logic [DW-1:0]        d_ff, d_in;
   logic [DW:0]          rem_ff, rem_in;
   logic [31:0]          frac_ff, frac_in;
   logic [29:0]          phi_ff, phi_in;
   logic [29:0]          z_ff, z_in;
   logic [30:0]          val_ff, val_in;
   logic [30:0]          s_ff, s_in;
   logic signed [31:0]   sn_ff, sn_in, cs_ff, cs_in;
   logic signed [63:0]   acc_ff, acc_in;
   logic signed [31:0]   ns_ff, ns_in, nc_ff, nc_in;
   logic signed [31:0]   osc_sine_ff, osc_sine_in, osc_cos_ff, osc_cos_in;
   logic                 out_valid_ff, out_valid_in;
   logic signed [15:0]   out_sample_ff, out_sample_in;

   logic signed [33:0]   mul_a, mul_b;
   logic signed [67:0]   mul_p, mul_sh;
   logic signed [63:0]   acc_sum, acc_rnd;
   logic signed [NW-1:0] q_n;
   logic [DW:0]          rem_sh, d_ext;
   logic [29:0]          u_val;
   logic [4:0]           step;
   logic [15:0]          sr_eff;
   logic signed [31:0]   s_sig, c_sig;
   logic signed [32:0]   smp_rnd;
   logic                 out_free;

   // Saturate a rounded rotation term to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'(x);
      end
      return r;
   endfunction

   assign out_empty  = !out_valid_ff;
   assign out_sample = out_sample_ff;
   assign out_free   = !out_valid_ff || out_pop;
   assign mul_p      = mul_a * mul_b;
   assign q_n        = $signed(q_data[NW-1:0]);
   assign sr_eff     = (rate_hz == 16'd0) ? 16'd1 : rate_hz;
   assign d_ext      = {1'b0, d_ff};
   assign step       = cnt_ff[4:0];
   assign s_sig      = $signed({1'b0, s_ff});
   assign c_sig      = $signed({1'b0, val_ff});
   assign smp_rnd    = (33'(osc_sine_ff) + 33'sd16384) >>> 15;

   // Sequence one item through the shared multiplier and the serial reducers
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      d_in          = d_ff;
      rem_in        = rem_ff;
      frac_in       = frac_ff;
      phi_in        = phi_ff;
      z_in          = z_ff;
      val_in        = val_ff;
      s_in          = s_ff;
      sn_in         = sn_ff;
      cs_in         = cs_ff;
      acc_in        = acc_ff;
      ns_in         = ns_ff;
      nc_in         = nc_ff;
      osc_sine_in   = osc_sine_ff;
      osc_cos_in    = osc_cos_ff;
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      q_pop         = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      mul_sh        = '0;
      rem_sh        = '0;
      u_val         = '0;
      acc_sum       = '0;
      acc_rnd       = '0;

      if (out_pop) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               neg_in = q_n[NW-1];
               mag_in = MW'(q_n[NW-1] ? -q_n : q_n);
               if (q_data[NW]) begin
                  osc_sine_in = '0;
                  osc_cos_in  = $signed({1'b0, cro_pkg::Q30_ONE});
               end
               state_in = ST_RATE;
            end
         end
         ST_RATE: begin
            mul_a    = $signed(34'(sr_eff));
            mul_b    = $signed(34'(SWEEP_LEN));
            d_in     = DW'(mul_p);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            // Shift in one magnitude bit, subtract the divisor when it fits
            rem_sh = {rem_ff[DW-1:0], mag_ff[MW-1]};
            rem_in = (rem_sh >= d_ext) ? rem_sh - d_ext : rem_sh;
            mag_in = mag_ff << 1;
            if (cnt_ff == CNT_W'(MW - 1)) begin
               cnt_in   = '0;
               state_in = ST_FIX;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FIX: begin
            if (neg_ff && (rem_ff != '0)) begin
               rem_in = d_ext - rem_ff;
            end
            cnt_in   = '0;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            // One quotient bit of the turn fraction per cycle
            rem_sh  = {rem_ff[DW-1:0], 1'b0};
            rem_in  = (rem_sh >= d_ext) ? rem_sh - d_ext : rem_sh;
            frac_in = {frac_ff[30:0], rem_sh >= d_ext};
            if (cnt_ff == CNT_W'(31)) begin
               state_in = ST_PHI;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PHI: begin
            // Mirror odd octants, scale to radians
            u_val    = frac_ff[29] ? (30'h2000_0000 - 30'(frac_ff[28:0]))
                                   : 30'(frac_ff[28:0]);
            mul_a    = $signed(34'(u_val));
            mul_b    = $signed(34'(cro_pkg::PI_Q30));
            mul_sh   = (mul_p + 68'sd1073741824) >>> 31;
            phi_in   = 30'(mul_sh);
            state_in = ST_Z;
         end
         ST_Z: begin
            mul_a    = $signed(34'(phi_ff));
            mul_b    = $signed(34'(phi_ff));
            mul_sh   = (mul_p + 68'sd536870912) >>> 30;
            z_in     = 30'(mul_sh);
            cnt_in   = '0;
            state_in = ST_POLY;
         end
         ST_POLY: begin
            // Even steps divide and subtract from one, odd steps multiply
            if (!step[0]) begin
               mul_a  = ((step == 5'd0) || (step == 5'd8)) ? $signed(34'(z_ff))
                                                           : $signed(34'(val_ff));
               mul_b  = $signed(34'(cro_pkg::poly_magic(step[4:1])));
               mul_sh = mul_p >>> cro_pkg::poly_shift(step[4:1]);
               val_in = cro_pkg::Q30_ONE - 31'(mul_sh);
            end else begin
               mul_a  = (step == 5'd7) ? $signed(34'(phi_ff)) : $signed(34'(z_ff));
               mul_b  = $signed(34'(val_ff));
               mul_sh = (mul_p + 68'sd536870912) >>> 30;
               val_in = 31'(mul_sh);
               if (step == 5'd7) begin
                  s_in = 31'(mul_sh);
               end
            end
            if (step == 5'd16) begin
               state_in = ST_MAP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MAP: begin
            // Octant symmetry
            unique case (frac_ff[31:29])
               3'd0: begin sn_in = s_sig;  cs_in = c_sig;  end
               3'd1: begin sn_in = c_sig;  cs_in = s_sig;  end
               3'd2: begin sn_in = c_sig;  cs_in = -s_sig; end
               3'd3: begin sn_in = s_sig;  cs_in = -c_sig; end
               3'd4: begin sn_in = -s_sig; cs_in = -c_sig; end
               3'd5: begin sn_in = -c_sig; cs_in = -s_sig; end
               3'd6: begin sn_in = -c_sig; cs_in = s_sig;  end
               3'd7: begin sn_in = -s_sig; cs_in = c_sig;  end
               default: begin sn_in = s_sig; cs_in = c_sig; end
            endcase
            cnt_in   = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            // Accumulate the two products of each rotated term
            unique case (cnt_ff[1:0])
               2'd0: begin
                  mul_a  = 34'(osc_cos_ff);
                  mul_b  = 34'(sn_ff);
                  acc_in = 64'(mul_p);
               end
               2'd1: begin
                  mul_a   = 34'(osc_sine_ff);
                  mul_b   = 34'(cs_ff);
                  acc_sum = acc_ff + 64'(mul_p);
                  acc_rnd = (acc_sum + 64'sd536870912) >>> 30;
                  ns_in   = sat32(acc_rnd);
               end
               2'd2: begin
                  mul_a  = 34'(osc_cos_ff);
                  mul_b  = 34'(cs_ff);
                  acc_in = 64'(mul_p);
               end
               2'd3: begin
                  mul_a    = 34'(osc_sine_ff);
                  mul_b    = 34'(sn_ff);
                  acc_sum  = acc_ff - 64'(mul_p);
                  acc_rnd  = (acc_sum + 64'sd536870912) >>> 30;
                  nc_in    = sat32(acc_rnd);
                  state_in = ST_DONE;
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
         end
         ST_DONE: begin
            // Present the pre-rotation sine and commit the rotated pair
            if (out_free) begin
               out_valid_in = 1'b1;
               if (smp_rnd > 33'sd32767) begin
                  out_sample_in = 16'sh7FFF;
               end else if (smp_rnd < -33'sd32768) begin
                  out_sample_in = 16'sh8000;
               end else begin
                  out_sample_in = 16'(smp_rnd);
               end
               osc_sine_in = ns_ff;
               osc_cos_in  = nc_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         osc_sine_ff  <= '0;
         osc_cos_ff   <= $signed({1'b0, cro_pkg::Q30_ONE});
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         osc_sine_ff  <= osc_sine_in;
         osc_cos_ff   <= osc_cos_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      d_ff          <= d_in;
      rem_ff        <= rem_in;
      frac_ff       <= frac_in;
      phi_ff        <= phi_in;
      z_ff          <= z_in;
      val_ff        <= val_in;
      s_ff          <= s_in;
      sn_ff         <= sn_in;
      cs_ff         <= cs_in;
      acc_ff        <= acc_in;
      ns_ff         <= ns_in;
      nc_ff         <= nc_in;
      out_sample_ff <= out_sample_in;
   end

endmodule

>>> hw/rtl/chirp_rotation_oscillator_top.sv
// Top level of the chirp rotation oscillator: sample rate register, front, queue and back.
// The back sequencer works on one item at a time and pops no new one until its result is
//   registered; it runs the bit-serial phase reduction over the MW-bit sweep numerator
//   (28 bits for a 2048-sample sweep), the 32-bit fraction division and 24 multiplier steps,
//   and it holds its result while the output register is still full.
// Reset: synchronous; clears queues, sets sample rate to 11025 and the pair to (0, 1.0).
module chirp_rotation_oscillator_top #(
   parameter int unsigned SWEEP_LEN = cro_pkg::SWEEP_LEN_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_restart,
   input  logic [15:0]        req_freq_start,
   input  logic [15:0]        req_freq_end,
   input  logic [10:0]        req_sample_index,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_rate_hz
);
   localparam int unsigned MW = $clog2(longint'(SWEEP_LEN) * 64'd65536 + 64'd134217728);
   localparam int unsigned QW = MW + 2;

   logic [15:0]   rate_hz_ff, rate_hz_in;
   logic          q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;

   // Hold the sample rate register
   assign csr_ready = 1'b1;
   always_comb begin
      rate_hz_in = rate_hz_ff;
      if (csr_valid && csr_ready) begin
         rate_hz_in = csr_rate_hz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_hz_ff <= cro_pkg::RATE_HZ_RESET;
      end else begin
         rate_hz_ff <= rate_hz_in;
      end
   end

   cro_front #(.SWEEP_LEN(SWEEP_LEN)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .restart      (req_restart),
      .freq_start   (req_freq_start),
      .freq_end     (req_freq_end),
      .sample_index (req_sample_index),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   cro_queue #(.WIDTH(QW), .DEPTH(cro_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   cro_back #(.SWEEP_LEN(SWEEP_LEN)) u_back (
      .clock       (clock),
      .reset       (reset),
      .rate_hz     (rate_hz_ff),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .q_data      (q_rdata),
      .out_empty   (rsp_empty),
      .out_pop     (rsp_pop),
      .out_sample  (rsp_sample)
   );

endmodule

>>> dv/tb_chirp_rotation_oscillator_top.sv
// Testbench for the chirp rotation oscillator: table-driven directed part, random chirps, scoreboard.
`timescale 1ns / 100ps

module tb_chirp_rotation_oscillator_top;

   localparam int unsigned SWEEP = 2048;
   localparam int unsigned LATENCY = 200;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam int NO_EXP = 99999;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_restart = 1'b0;
   logic [15:0]        req_freq_start = '0;
   logic [15:0]        req_freq_end = '0;
   logic [10:0]        req_sample_index = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [15:0] rsp_sample;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [15:0]        csr_rate_hz = '0;

   chirp_rotation_oscillator_top u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_restart(req_restart),
      .req_freq_start(req_freq_start), .req_freq_end(req_freq_end),
      .req_sample_index(req_sample_index),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_sample(rsp_sample),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_rate_hz(csr_rate_hz)
   );

   always #6 clock = ~clock;

   // Predictor state
   logic [15:0]         rate_q;
   logic signed [63:0]  sine_q, cosine_q;
   logic signed [15:0]  sample_fifo[$];
   int                  errors = 0;
   int                  n_sent = 0, n_got = 0;
   longint              cycles = 0;
   int                  send_idle_pct = 0, recv_idle_pct = 0;
   int                  hold_cycles = 0;

   function automatic logic [63:0] umul_q30(logic [63:0] a, logic [63:0] b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic signed [63:0] round_shift(logic signed [63:0] x, int sh);
      logic [63:0] u;
      u = 64'(x) + (64'd1 << 62) + (64'd1 << (sh - 1));
      return $signed(u >> sh) - $signed(64'd1 << (62 - sh));
   endfunction

   function automatic logic signed [63:0] clamp(logic signed [63:0] x, logic signed [63:0] lo,
                                                logic signed [63:0] hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // Sine and cosine of a Q0.32 turn fraction, Q2.30 results
   task automatic turn_sincos(input logic [31:0] frac, output logic signed [63:0] sn,
                              output logic signed [63:0] cs);
      logic [2:0]  oct;
      logic [63:0] u, phi, z, t, s, c;
      logic [63:0] one;
      logic signed [63:0] ss, cc;
      one = 64'd1 << 30;
      oct = frac[31:29];
      u = {35'd0, frac[28:0]};
      if (oct[0]) u = (64'd1 << 29) - u;
      phi = (u * 64'd3373259426 + (64'd1 << 30)) >> 31;
      z = umul_q30(phi, phi);
      t = one - z / 72;
      t = one - umul_q30(z, t) / 42;
      t = one - umul_q30(z, t) / 20;
      t = one - umul_q30(z, t) / 6;
      s = umul_q30(phi, t);
      t = one - z / 90;
      t = one - umul_q30(z, t) / 56;
      t = one - umul_q30(z, t) / 30;
      t = one - umul_q30(z, t) / 12;
      c = one - umul_q30(z, t) / 2;
      ss = $signed(s);
      cc = $signed(c);
      case (oct)
         3'd0: begin sn = ss; cs = cc; end
         3'd1: begin sn = cc; cs = ss; end
         3'd2: begin sn = cc; cs = -ss; end
         3'd3: begin sn = ss; cs = -cc; end
         3'd4: begin sn = -ss; cs = -cc; end
         3'd5: begin sn = -cc; cs = -ss; end
         3'd6: begin sn = -cc; cs = ss; end
         default: begin sn = -ss; cs = cc; end
      endcase
   endtask

   // Advance the oscillator by one sample, return the pre-rotation sine
   task automatic chirp_predict(input logic rst, input logic [15:0] fa, input logic [15:0] fb,
                                input logic [10:0] idx, output logic signed [15:0] smp);
      logic signed [63:0] n, d, r, sn, cs, ns, nc;
      logic [31:0] frac;
      d = 64'(SWEEP) * (rate_q == 0 ? 64'sd1 : 64'(rate_q));
      if (rst) begin
         sine_q = 0;
         cosine_q = 64'sd1 << 30;
      end
      n = 64'(fa) * SWEEP + (64'(fb) - 64'(fa)) * 64'(idx);
      r = n % d;
      if (r < 0) r += d;
      frac = 32'((64'(r) << 32) / 64'(d));
      turn_sincos(frac, sn, cs);
      smp = 16'(clamp(round_shift(sine_q, 15), -32768, 32767));
      ns = round_shift(cosine_q * sn + sine_q * cs, 30);
      nc = round_shift(cosine_q * cs - sine_q * sn, 30);
      sine_q = clamp(ns, -64'sd2147483648, 64'sd2147483647);
      cosine_q = clamp(nc, -64'sd2147483648, 64'sd2147483647);
   endtask

   // Offer one item and wait for its transfer; typed expectation when not NO_EXP
   task automatic send_tick(input logic rst, input logic [15:0] fa, input logic [15:0] fb,
                            input logic [10:0] idx, input int typed);
      logic signed [15:0] smp;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_restart <= rst;
      req_freq_start <= fa;
      req_freq_end <= fb;
      req_sample_index <= idx;
      @(posedge clock);
      while (req_full) @(posedge clock);
      chirp_predict(rst, fa, fb, idx, smp);
      if (typed != NO_EXP && smp != 16'(typed)) begin
         $error("table sample: expected %0d, predictor %0d", typed, smp);
         errors++;
      end
      sample_fifo.push_back(smp);
      n_sent++;
   endtask

   // Drop the input request and wait until every expected sample has come back
   task automatic drain();
      req_push <= 1'b0;
      wait (n_got == n_sent);
   endtask

   // Wait for the pipeline to drain, then write the sample rate
   task automatic write_rate(input logic [15:0] rate);
      drain();
      repeat (LATENCY) @(posedge clock);
      csr_valid <= 1'b1;
      csr_rate_hz <= rate;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      rate_q = rate;
   endtask

   // Receiver: pop with random idling or a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (sample_fifo.size() == 0) begin
               $error("unexpected sample %0d", rsp_sample);
               errors++;
            end else begin
               if (rsp_sample !== sample_fifo[0]) begin
                  $error("sample: expected %0d, actual %0d", sample_fifo[0], rsp_sample);
                  errors++;
               end
               void'(sample_fifo.pop_front());
            end
            n_got++;
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   typedef struct {
      logic rst; logic [15:0] fa; logic [15:0] fb; logic [10:0] idx; int typed;
   } tick_row_type;

   tick_row_type ticks[$];

   // Random chirp: mostly sweeps through consecutive indexes, some noise
   task automatic random_phase(input int count);
      logic [15:0] fa, fb;
      int idx, k, run_len;
      k = 0;
      while (k < count) begin
         fa = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
         fb = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
         idx = $urandom_range(2047);
         run_len = $urandom_range(40, 1);
         for (int j = 0; j < run_len && k < count; j++) begin
            send_tick((j == 0) ? 1'($urandom_range(1)) : ($urandom_range(30) == 0),
                      fa, fb, 11'(idx + j), NO_EXP);
            k++;
         end
      end
   endtask

   initial begin
      rate_q = cro_pkg::RATE_HZ_RESET;
      sine_q = 0;
      cosine_q = 64'sd1 << 30;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: reset state, extremes, quarter turn
      ticks = '{
         '{1'b0, 16'd0, 16'd0, 11'd0, 0},
         '{1'b1, 16'd0, 16'd0, 11'd0, 0},
         '{1'b0, 16'hFFFF, 16'hFFFF, 11'h7FF, NO_EXP},
         '{1'b0, 16'hFFFF, 16'd0, 11'h7FF, NO_EXP},
         '{1'b0, 16'd0, 16'hFFFF, 11'h7FF, NO_EXP},
         '{1'b1, 16'd2756, 16'd2756, 11'd0, 0},
         '{1'b0, 16'd2756, 16'd2756, 11'd1, NO_EXP},
         '{1'b0, 16'd2756, 16'd2756, 11'd2, NO_EXP},
         '{1'b0, 16'd2756, 16'd2756, 11'd3, NO_EXP},
         '{1'b0, 16'd2756, 16'd2756, 11'd4, NO_EXP},
         '{1'b0, 16'h5555, 16'hAAAA, 11'h555, NO_EXP},
         '{1'b0, 16'hAAAA, 16'h5555, 11'h2AA, NO_EXP}
      };
      send_idle_pct = 6;
      recv_idle_pct = 60;
      foreach (ticks[i]) send_tick(ticks[i].rst, ticks[i].fa, ticks[i].fb, ticks[i].idx,
                                   ticks[i].typed);

      // Sample rate extremes, zero treated as one
      write_rate(16'd0);
      send_tick(1'b1, 16'd1, 16'hFFFF, 11'd100, 0);
      send_tick(1'b0, 16'd1, 16'hFFFF, 11'd101, NO_EXP);
      write_rate(16'd1);
      send_tick(1'b0, 16'd3, 16'd7, 11'd9, NO_EXP);
      write_rate(16'hFFFF);
      send_tick(1'b1, 16'hFFFF, 16'hFFFF, 11'd0, 0);
      send_tick(1'b0, 16'hFFFF, 16'hFFFF, 11'd1, NO_EXP);
      write_rate(16'd11025);

      random_phase(400);

      // Hold off the receiver while the sender keeps pushing
      hold_cycles = 3000;
      random_phase(30);
      drain();

      write_rate(16'd48000);
      send_idle_pct = 60;
      recv_idle_pct = 6;
      random_phase(400);

      write_rate(16'($urandom_range(65535, 1)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(450);

      drain();
      repeat (LATENCY) @(posedge clock);
      $display("Sent %0d ticks, checked %0d samples over several sample rates and chirps.",
               n_sent, n_got);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/cro_pkg.sv
hw/rtl/cro_queue.sv
hw/rtl/cro_front.sv
hw/rtl/cro_back.sv
hw/rtl/chirp_rotation_oscillator_top.sv
dv/tb_chirp_rotation_oscillator_top.sv
